// ===== src/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Traction control CAN node package
// Shared constants, codes, register layout and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

   // Default width of the message age counters.
   localparam int AGE_WIDTH_DEF = 8;

   // Input command codes.
   localparam logic [1:0] CMD_FRAME = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_STEP  = 2'd2;

   // CAN identifiers.
   localparam logic [10:0] ID_WHEEL_SPEED = 11'h1f0;
   localparam logic [10:0] ID_TORQUE_2    = 11'h1c3;
   localparam logic [10:0] ID_TORQUE_3    = 11'h2c3;
   localparam logic [10:0] ID_TRANS       = 11'h1f5;
   localparam logic [10:0] ID_TX          = 11'h1c7;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_GAIN_P       = 3'd0;
   localparam logic [2:0] REG_GAIN_I       = 3'd1;
   localparam logic [2:0] REG_GAIN_D       = 3'd2;
   localparam logic [2:0] REG_MIN_FRONT    = 3'd3;
   localparam logic [2:0] REG_MIN_TORQUE   = 3'd4;
   localparam logic [2:0] REG_SLIP_ENABLE  = 3'd5;
   localparam logic [2:0] REG_SLIP_DISABLE = 3'd6;
   localparam logic [2:0] REG_SLIP_TARGET  = 3'd7;

   // Divider geometry: dividend and divisor widths.
   localparam int DIV_NW = 36;
   localparam int DIV_DW = 18;

   // Configuration register set.
   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic [12:0]        min_front_speed;
      logic [11:0]        min_driver_torque;
      logic signed [13:0] slip_enable;
      logic signed [13:0] slip_disable;
      logic signed [13:0] slip_target;
   } cfg_type;

   // Multiplier operand selection.
   typedef enum logic [2:0] {
      MUL_NONE = 3'd0,
      MUL_AXLE = 3'd1,
      MUL_I    = 3'd2,
      MUL_P    = 3'd3,
      MUL_D    = 3'd4
   } mul_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       eval;
      logic       prime;
      logic       div_i;
      logic       acc_load;
      logic       acc_add;
      logic       upd_i;
      logic       sum_out;
      logic       decide;
      logic       finish;
      mul_op_type mul_op;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic inputs_ok;
      logic active;
      logic div_busy;
      logic need_div;
   } status_type;

   // Total ratio per gear, Q5.12; unknown gears read as zero.
   function automatic logic [16:0] gear_ratio(input logic [3:0] gear);
      logic [16:0] r;
      case (gear)
         4'd1: r = 17'd73892;
         4'd2: r = 17'd43495;
         4'd3: r = 17'd30228;
         4'd4: r = 17'd22503;
         4'd5: r = 17'd16794;
         4'd6: r = 17'd12595;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/tcc_if.sv =====
// ----------------------------------------------------------------------------
// Traction control CAN node channels
// Valid/ready channels for command words and transmitted frame words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [10:0] frame_id;
   logic [63:0] frame_data;

   modport source (output valid, command, frame_id, frame_data, input ready);
   modport sink (input valid, command, frame_id, frame_data, output ready);
endinterface

interface tcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] out_id;
   logic [63:0] out_data;
   logic        frame_kind;
   logic        last_frame;

   modport source (output valid, out_id, out_data, frame_kind, last_frame, input ready);
   modport sink (input valid, out_id, out_data, frame_kind, last_frame, output ready);
endinterface

`default_nettype wire

// ===== src/tcc_div.sv =====
// ----------------------------------------------------------------------------
// Traction control sequential divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div
   import tcc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_NW-1:0] dividend,
   input  wire logic [DIV_DW-1:0] divisor,
   output logic                   busy,
   output logic [DIV_NW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [DIV_DW:0]   rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_DW:0]   shifted;
   logic [DIV_DW+1:0] trial;

   // One restoring step per cycle.
   always_comb begin
      shifted = {rem_ff[DIV_DW-1:0], quo_ff[DIV_NW-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_DW+1]) begin
            rem_in = trial[DIV_DW:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Traction control controller
// Sequences a control step through the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_ctrl
   import tcc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_valid,
   input  wire logic [1:0] in_command,
   output logic       in_ready,
   output logic       out_valid,
   input  wire logic  out_ready,
   output logic       out_torque,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [14:0] {
      ST_IDLE      = 15'b000000000000001,
      ST_EVAL      = 15'b000000000000010,
      ST_MUL_AXLE  = 15'b000000000000100,
      ST_PRIME     = 15'b000000000001000,
      ST_DIVI_GO   = 15'b000000000010000,
      ST_MUL_D     = 15'b000000000100000,
      ST_ACC_D     = 15'b000000001000000,
      ST_DIVI_WAIT = 15'b000000010000000,
      ST_UPD_I     = 15'b000000100000000,
      ST_SUM_OUT   = 15'b000001000000000,
      ST_DECIDE    = 15'b000010000000000,
      ST_DIVR_WAIT = 15'b000100000000000,
      ST_FINISH    = 15'b001000000000000,
      ST_SEND_STAT = 15'b010000000000000,
      ST_SEND_TORQ = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_op = MUL_NONE;
      in_ready   = 1'b0;
      out_valid  = 1'b0;
      out_torque = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready   = 1'b1;
            cmd.accept = in_valid;
            if (in_valid && in_command == CMD_STEP) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (!stat.inputs_ok) begin
               state_in = ST_IDLE;
            end else if (stat.active) begin
               state_in = ST_MUL_AXLE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL_AXLE: begin
            cmd.mul_op = MUL_AXLE;
            state_in   = ST_PRIME;
         end
         ST_PRIME: begin
            cmd.prime  = 1'b1;
            cmd.mul_op = MUL_I;
            state_in   = ST_DIVI_GO;
         end
         ST_DIVI_GO: begin
            cmd.div_i  = 1'b1;
            cmd.mul_op = MUL_P;
            state_in   = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.acc_load = 1'b1;
            cmd.mul_op   = MUL_D;
            state_in     = ST_ACC_D;
         end
         ST_ACC_D: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_DIVI_WAIT;
         end
         ST_DIVI_WAIT: begin
            if (!stat.div_busy) begin
               state_in = ST_UPD_I;
            end
         end
         ST_UPD_I: begin
            cmd.upd_i = 1'b1;
            state_in  = ST_SUM_OUT;
         end
         ST_SUM_OUT: begin
            cmd.sum_out = 1'b1;
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.need_div ? ST_DIVR_WAIT : ST_FINISH;
         end
         ST_DIVR_WAIT: begin
            if (!stat.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_SEND_STAT;
         end
         ST_SEND_STAT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_SEND_TORQ;
            end
         end
         ST_SEND_TORQ: begin
            out_valid  = 1'b1;
            out_torque = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tcc_dp.sv =====
// ----------------------------------------------------------------------------
// Traction control datapath
// Frame decoding, message ages, slip gates, PID arithmetic and frame build.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_dp
   import tcc_pkg::*;
#(
   parameter int AGE_WIDTH = AGE_WIDTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cmd_type          cmd,
   output status_type       stat,
   input  cfg_type          cfg,
   input  wire logic [1:0]  in_command,
   input  wire logic [10:0] in_frame_id,
   input  wire logic [63:0] in_frame_data,
   output logic [63:0]      status_data,
   output logic [63:0]      torque_data
);

   localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

   // Decoded message state.
   logic [12:0]          front_ff, rear_ff;
   logic signed [12:0]   dt_ff;
   logic [3:0]           flags_ff;
   logic [3:0]           gear_ff;
   logic [AGE_WIDTH-1:0] age_ff [4];

   // Regulator state.
   logic                 latch_ff, was_active_ff, active_ff;
   logic signed [39:0]   integ_ff;
   logic signed [15:0]   pe_ff;
   logic signed [12:0]   prev_req_ff;
   logic [1:0]           rc_ff;

   // Step working registers.
   logic signed [15:0]   err_ff;
   logic [16:0]          ratio_ff;
   logic signed [35:0]   prod_ff;
   logic signed [30:0]   axle_ff;
   logic signed [36:0]   acc_ff;
   logic signed [41:0]   out_ff;
   logic                 neg_ff;
   logic signed [12:0]   req_ff;
   logic                 use_quot_ff;
   logic [63:0]          stat_data_ff, torq_data_ff;

   // Byte-swapped payload for Motorola extraction.
   logic [63:0] sw;
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         sw[63 - 8*k -: 8] = in_frame_data[8*k +: 8];
      end
   end

   logic [12:0]        front_dec, rear_dec;
   logic signed [12:0] dt_dec;
   assign front_dec = {1'b0, sw[56:45]} + {1'b0, sw[40:29]};
   assign rear_dec  = {1'b0, sw[24:13]} + {1'b0, sw[8:0], 3'b000};
   assign dt_dec    = $signed({sw[43], sw[43:32]}) - 13'sd1696;

   // Freshness and validity of all inputs.
   assign stat.inputs_ok = (age_ff[0] <= AGE_WIDTH'(50)) && (age_ff[1] <= AGE_WIDTH'(100))
                        && (age_ff[2] <= AGE_WIDTH'(200)) && (age_ff[3] <= AGE_WIDTH'(100))
                        && (flags_ff == 4'hf);

   // Gates and slip hysteresis.
   logic signed [13:0] slip;
   logic               gates, latch_next;
   logic signed [15:0] err_now;
   assign slip  = $signed({1'b0, rear_ff}) - $signed({1'b0, front_ff});
   assign gates = (front_ff > cfg.min_front_speed)
               && (dt_ff > $signed({1'b0, cfg.min_driver_torque}));
   always_comb begin
      latch_next = latch_ff;
      if (slip > cfg.slip_enable) begin
         latch_next = 1'b1;
      end else if (slip < cfg.slip_disable) begin
         latch_next = 1'b0;
      end
   end
   assign stat.active = gates && latch_next;
   assign err_now     = 16'(cfg.slip_target) - 16'(slip);

   // Shared multiplier with registered product.
   logic signed [17:0] mul_a, mul_b;
   logic signed [16:0] err_diff;
   assign err_diff = 17'(err_ff) - 17'(pe_ff);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_AXLE: begin
            mul_a = 18'(dt_ff);
            mul_b = $signed({1'b0, ratio_ff});
         end
         MUL_I: begin
            mul_a = 18'(cfg.gain_i);
            mul_b = 18'(err_ff);
         end
         MUL_P: begin
            mul_a = 18'(cfg.gain_p);
            mul_b = 18'(err_ff);
         end
         MUL_D: begin
            mul_a = 18'(cfg.gain_d);
            mul_b = 18'(err_diff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Integral term: (|gain_i*e| + 200) / 400 as a shift by four and a
   // multiplication by the reciprocal of 25, exact for dividends below 2^30.
   localparam logic [26:0] RECIP_25 = 27'd85899346;
   logic signed [35:0] prod_abs;
   logic [35:0]        prod_rnd;
   logic [25:0]        rnd_ff;
   logic [52:0]        qi_prod;
   logic [21:0]        qi_ff;
   assign prod_abs = prod_ff[35] ? -prod_ff : prod_ff;
   assign prod_rnd = 36'(prod_abs) + 36'd200;
   assign qi_prod  = 53'(rnd_ff) * 53'(RECIP_25);

   // Divider: axle torque by the gear ratio.
   logic              div_start, div_busy;
   logic [DIV_NW-1:0] quot;
   logic              need_div;
   assign need_div  = (ratio_ff != 17'd0) && (out_ff > 42'sd0);
   assign div_start = cmd.decide && need_div;

   tcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (out_ff[DIV_NW-1:0]),
      .divisor  ({1'b0, ratio_ff}),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign stat.div_busy = div_busy;
   assign stat.need_div = need_div;

   // Integrator update with clamp to [0, axle].
   logic signed [40:0] q_signed, integ_sum, axle_ext, integ_clip;
   assign q_signed   = neg_ff ? -$signed({19'b0, qi_ff}) : $signed({19'b0, qi_ff});
   assign integ_sum  = 41'(integ_ff) + q_signed;
   assign axle_ext   = 41'(axle_ff);
   assign integ_clip = (integ_sum > axle_ext) ? axle_ext : integ_sum;

   // Half of the P plus D sum, rounded away from zero on ties.
   logic signed [37:0] acc_half;
   assign acc_half = acc_ff[36] ? -((-38'(acc_ff) + 38'sd1) >>> 1)
                                : ((38'(acc_ff) + 38'sd1) >>> 1);

   // Final request and the two transmitted frames.
   logic signed [12:0] req_fin;
   logic signed [13:0] req_w, prev_w;
   logic [1:0]         code, rc_next;
   logic [11:0]        val;
   logic [17:0]        packet;
   logic [13:0]        prot;
   logic [7:0]         b3;
   always_comb begin
      if (use_quot_ff && ($signed({1'b0, quot}) < 37'(dt_ff))) begin
         req_fin = $signed(quot[12:0]);
      end else if (use_quot_ff) begin
         req_fin = dt_ff;
      end else begin
         req_fin = req_ff;
      end
      req_w   = 14'(req_fin);
      prev_w  = 14'(prev_req_ff);
      rc_next = rc_ff + 2'd1;
      if (req_w > prev_w + 14'sd10) begin
         code = 2'd1;
      end else if (req_w < prev_w - 14'sd10) begin
         code = 2'd2;
      end else begin
         code = 2'd0;
      end
      val    = 12'(req_fin + 13'sd1696);
      packet = {code, 4'b0000, val};
      prot   = 14'd0 - (packet[13:0] + {12'b0, rc_next});
      b3     = (code != 2'd0) ? 8'h1c : 8'h0c;
   end

   // Register updates.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      qi_ff   <= qi_prod[52:31];
      if (cmd.eval) begin
         err_ff      <= err_now;
         ratio_ff    <= (gear_ff <= 4'd6) ? gear_ratio(gear_ff) : 17'd0;
         req_ff      <= dt_ff;
         use_quot_ff <= 1'b0;
      end
      if (cmd.prime) begin
         axle_ff <= prod_ff[30:0];
      end
      if (cmd.div_i) begin
         neg_ff <= prod_ff[35];
         rnd_ff <= prod_rnd[29:4];
      end
      if (cmd.acc_load) begin
         acc_ff <= 37'(prod_ff);
      end
      if (cmd.acc_add) begin
         acc_ff <= acc_ff + 37'(prod_ff);
      end
      if (cmd.sum_out) begin
         out_ff <= 42'(integ_ff) + 42'(acc_half);
      end
      if (cmd.decide) begin
         if (ratio_ff == 17'd0) begin
            req_ff <= (out_ff < 42'sd0) ? 13'sd0 : dt_ff;
         end else if (!(out_ff > 42'sd0)) begin
            req_ff <= 13'sd0;
         end else begin
            use_quot_ff <= 1'b1;
         end
      end
      if (cmd.finish) begin
         stat_data_ff <= {8'h00, 8'h04, 8'h00, 8'hf0, b3, 8'h00, 8'h00, 8'h90};
         torq_data_ff <= {5'b0, 6'd50, 2'b0, prot, 12'b0, rc_next, packet, 5'b0};
      end

      if (reset) begin
         front_ff      <= '0;
         rear_ff       <= '0;
         dt_ff         <= '0;
         flags_ff      <= '0;
         gear_ff       <= '0;
         for (int k = 0; k < 4; k++) begin
            age_ff[k] <= AGE_MAX;
         end
         latch_ff      <= 1'b0;
         was_active_ff <= 1'b0;
         active_ff     <= 1'b0;
         integ_ff      <= '0;
         pe_ff         <= '0;
         prev_req_ff   <= '0;
         rc_ff         <= '0;
      end else begin
         // Received frames and millisecond ticks.
         if (cmd.accept && in_command == CMD_FRAME) begin
            case (in_frame_id)
               ID_WHEEL_SPEED: begin
                  front_ff  <= front_dec;
                  rear_ff   <= rear_dec;
                  age_ff[0] <= '0;
               end
               ID_TORQUE_2: begin
                  flags_ff[0] <= ~in_frame_data[4];
                  dt_ff       <= dt_dec;
                  age_ff[1]   <= '0;
               end
               ID_TORQUE_3: begin
                  flags_ff[1] <= ~in_frame_data[20];
                  flags_ff[2] <= ~in_frame_data[4];
                  age_ff[2]   <= '0;
               end
               ID_TRANS: begin
                  gear_ff     <= in_frame_data[3:0];
                  flags_ff[3] <= ~in_frame_data[4];
                  age_ff[3]   <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.accept && in_command == CMD_TICK) begin
            for (int k = 0; k < 4; k++) begin
               if (age_ff[k] != AGE_MAX) begin
                  age_ff[k] <= age_ff[k] + AGE_WIDTH'(1);
               end
            end
         end
         // Gate evaluation only on a step with fresh inputs.
         if (cmd.eval && stat.inputs_ok) begin
            if (gates) begin
               latch_ff <= latch_next;
            end
            active_ff <= stat.active;
         end
         // Engagement primes the integrator and the previous error.
         if (cmd.prime && !was_active_ff) begin
            integ_ff <= 40'(prod_ff[30:0]);
            pe_ff    <= err_ff;
         end
         if (cmd.upd_i) begin
            integ_ff <= (integ_clip < 41'sd0) ? 40'sd0 : integ_clip[39:0];
         end
         if (cmd.sum_out) begin
            pe_ff <= err_ff;
         end
         if (cmd.finish) begin
            prev_req_ff   <= req_fin;
            rc_ff         <= rc_next;
            was_active_ff <= active_ff;
         end
      end
   end

   assign status_data = stat_data_ff;
   assign torque_data = torq_data_ff;

endmodule

`default_nettype wire

// ===== src/traction_control_can_node.sv =====
// ----------------------------------------------------------------------------
// Traction control CAN node
// Decodes received CAN frames and runs the slip regulator on control steps.
// ----------------------------------------------------------------------------
// Command words are taken one at a time. A control step with stale or invalid
// inputs sends nothing. An active step runs through one shared 18x18
// multiplier, a reciprocal multiplication for the integral term, and a
// restoring divider for the ratio conversion when one is needed. Every step
// with fresh inputs offers the status word and the torque request word,
// status first. A stall on the result channel holds the block. Registers are
// written over the APB port at byte address 4*i and must only be written
// while the block is idle.
`default_nettype none

module traction_control_can_node
   import tcc_pkg::*;
#(
   parameter int AGE_WIDTH = AGE_WIDTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   tcc_req_if.sink          req_ch,
   tcc_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type stat;
   logic       out_torque;
   logic [63:0] status_data, torque_data;
   logic [2:0] reg_idx;

   assign reg_idx = paddr[4:2];
   assign pready  = 1'b1;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_GAIN_P:       cfg_in.gain_p            = pwdata[15:0];
            REG_GAIN_I:       cfg_in.gain_i            = pwdata[15:0];
            REG_GAIN_D:       cfg_in.gain_d            = pwdata[15:0];
            REG_MIN_FRONT:    cfg_in.min_front_speed   = pwdata[12:0];
            REG_MIN_TORQUE:   cfg_in.min_driver_torque = pwdata[11:0];
            REG_SLIP_ENABLE:  cfg_in.slip_enable       = pwdata[13:0];
            REG_SLIP_DISABLE: cfg_in.slip_disable      = pwdata[13:0];
            REG_SLIP_TARGET:  cfg_in.slip_target       = pwdata[13:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p            <= 16'sd0;
         cfg_ff.gain_i            <= 16'sd0;
         cfg_ff.gain_d            <= 16'sd0;
         cfg_ff.min_front_speed   <= 13'd1280;
         cfg_ff.min_driver_torque <= 12'd100;
         cfg_ff.slip_enable       <= 14'sd448;
         cfg_ff.slip_disable      <= 14'sd192;
         cfg_ff.slip_target       <= 14'sd384;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      case (reg_idx)
         REG_GAIN_P:       prdata = {16'b0, cfg_ff.gain_p};
         REG_GAIN_I:       prdata = {16'b0, cfg_ff.gain_i};
         REG_GAIN_D:       prdata = {16'b0, cfg_ff.gain_d};
         REG_MIN_FRONT:    prdata = {19'b0, cfg_ff.min_front_speed};
         REG_MIN_TORQUE:   prdata = {20'b0, cfg_ff.min_driver_torque};
         REG_SLIP_ENABLE:  prdata = {18'b0, cfg_ff.slip_enable};
         REG_SLIP_DISABLE: prdata = {18'b0, cfg_ff.slip_disable};
         REG_SLIP_TARGET:  prdata = {18'b0, cfg_ff.slip_target};
         default:          prdata = 32'b0;
      endcase
   end

   tcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_command (req_ch.command),
      .in_ready   (req_ch.ready),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_torque (out_torque),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcc_dp #(
      .AGE_WIDTH (AGE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .cfg           (cfg_ff),
      .in_command    (req_ch.command),
      .in_frame_id   (req_ch.frame_id),
      .in_frame_data (req_ch.frame_data),
      .status_data   (status_data),
      .torque_data   (torque_data)
   );

   // Result word payload.
   assign rsp_ch.out_id     = ID_TX;
   assign rsp_ch.out_data   = out_torque ? torque_data : status_data;
   assign rsp_ch.frame_kind = out_torque;
   assign rsp_ch.last_frame = out_torque;

   // A step never takes a new command while it still offers a result word.
   a_busy_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("command taken while a result word is pending");

   // The torque request word follows a taken status word.
   a_torque_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.frame_kind)
      |=> (rsp_ch.valid && rsp_ch.frame_kind))
      else $error("status word not followed by torque request word");

   // A taken torque request word returns the block to accepting commands.
   a_ready_after_torque: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.frame_kind) |=> req_ch.ready)
      else $error("block not ready after the final word of a step");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traction control CAN node testbench
// Drives received frames, millisecond ticks and control steps through the
// command channel, predicts every transmitted word with an in-bench model of
// the decoder and slip regulator, and checks each word as it leaves. Several
// register settings are applied over APB between phases.
// ----------------------------------------------------------------------------
module tb
   import tcc_pkg::*;
();

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_TORQUE = 1'b1;
   localparam int   ITEMS_PER_PHASE = 240;
   localparam int   IDLE_CYCLES = 200;

   typedef struct {
      logic [10:0] id;
      logic [63:0] data;
      logic        kind;
      logic        last;
   } can_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel, penable, pwrite, pready;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;

   tcc_req_if req_ch();
   tcc_rsp_if rsp_ch();

   traction_control_can_node u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   // Regulator settings as the block should hold them.
   longint kp, ki, kd, gate_front, gate_torque, slip_on, slip_off, slip_set;
   // Decoded vehicle state.
   longint front_sum, rear_sum, drv_torque;
   logic [3:0] valid_bits, gear;
   logic [7:0] age_ms[4];
   bit     latched, regulating;
   longint integ, last_err, last_req;
   logic [1:0] roll;

   can_word_type frames_due[$];
   can_word_type got, want;
   int errors = 0;
   int items_sent = 0;
   int steps_sent = 0;
   int frames_checked = 0;
   int burst_left = 0;

   task automatic report(input string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   // Motorola bit order: start at the named bit, walk down, then into the
   // next byte from bit 7. Bits past byte 7 read as zero.
   function automatic logic [11:0] moto_get(input logic [63:0] d, input int pos,
                                            input int len);
      int byt, bt;
      logic [11:0] r;
      byt = pos / 8;
      bt = pos % 8;
      r = '0;
      for (int k = 0; k < len; k++) begin
         r = {r[10:0], (byt < 8) ? d[byt*8+bt] : 1'b0};
         if (bt == 0) begin
            byt++;
            bt = 7;
         end else begin
            bt--;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] moto_put(input logic [63:0] d, input int pos,
                                            input int len, input logic [11:0] v);
      int byt, bt;
      byt = pos / 8;
      bt = pos % 8;
      for (int k = 0; k < len; k++) begin
         if (byt < 8) d[byt*8+bt] = v[len-1-k];
         if (bt == 0) begin
            byt++;
            bt = 7;
         end else begin
            bt--;
         end
      end
      return d;
   endfunction

   function automatic longint sx(input longint v, input int w);
      longint m;
      m = longint'(1) << (w - 1);
      v = v & ((m << 1) - 1);
      return (v ^ m) - m;
   endfunction

   // Round to nearest, ties away from zero.
   function automatic longint round_div(input longint n, input longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint ratio_q12(input logic [3:0] g);
      case (g)
         4'd1: return 73892;
         4'd2: return 43495;
         4'd3: return 30228;
         4'd4: return 22503;
         4'd5: return 16794;
         4'd6: return 12595;
         default: return 0;
      endcase
   endfunction

   function automatic bit inputs_fresh();
      if (age_ms[0] > 50 || age_ms[1] > 100) return 0;
      if (age_ms[2] > 200 || age_ms[3] > 100) return 0;
      return valid_bits == 4'hf;
   endfunction

   // PID in the axle-torque domain, converted back to engine torque.
   function automatic longint torque_request();
      longint r, axle, err, pid;
      r = ratio_q12(gear);
      axle = drv_torque * r;
      err = slip_set - (rear_sum - front_sum);
      if (!regulating) begin
         integ = axle;
         last_err = err;
      end
      integ += round_div(ki * err, 400);
      if (integ > axle) integ = axle;
      if (integ < 0) integ = 0;
      pid = integ + round_div(kp * err + kd * (err - last_err), 2);
      last_err = err;
      if (r == 0) return (pid < 0) ? 0 : drv_torque;
      if (pid <= 0) return 0;
      pid = pid / r;
      return (pid < drv_torque) ? pid : drv_torque;
   endfunction

   // Updates the state for one accepted word and queues the frames it causes.
   function automatic int predict_frames(input logic [1:0] cmd, input logic [10:0] id,
                                         input logic [63:0] d);
      longint slip, req;
      bit act;
      logic [1:0] code;
      logic [11:0] val;
      logic [17:0] packet;
      logic [13:0] prot;
      logic [7:0] b3;
      can_word_type w;
      if (cmd == CMD_FRAME) begin
         case (id)
            ID_WHEEL_SPEED: begin
               front_sum = moto_get(d, 0, 12) + moto_get(d, 16, 12);
               rear_sum = moto_get(d, 32, 12) + moto_get(d, 48, 12);
               age_ms[0] = 0;
            end
            ID_TORQUE_2: begin
               valid_bits[0] = ~d[4];
               drv_torque = sx(moto_get(d, 19, 12), 12) - 1696;
               age_ms[1] = 0;
            end
            ID_TORQUE_3: begin
               valid_bits[1] = ~d[20];
               valid_bits[2] = ~d[4];
               age_ms[2] = 0;
            end
            ID_TRANS: begin
               gear = d[3:0];
               valid_bits[3] = ~d[4];
               age_ms[3] = 0;
            end
            default: ;
         endcase
         return 0;
      end
      if (cmd == CMD_TICK) begin
         for (int i = 0; i < 4; i++) if (age_ms[i] != 8'hff) age_ms[i]++;
         return 0;
      end
      if (cmd != CMD_STEP || !inputs_fresh()) return 0;

      slip = rear_sum - front_sum;
      act = 0;
      if (front_sum > gate_front && drv_torque > gate_torque) begin
         if (slip > slip_on) latched = 1;
         else if (slip < slip_off) latched = 0;
         act = latched;
      end
      req = act ? torque_request() : drv_torque;
      regulating = act;
      roll = roll + 2'd1;
      code = 2'd0;
      if (req > last_req + 10) code = 2'd1;
      else if (req < last_req - 10) code = 2'd2;

      b3 = 8'h0c | ((code != 2'd0) ? 8'h10 : 8'h00);
      w.id = ID_TX;
      w.data = 64'h90 | (64'(b3) << 24) | (64'hf0 << 32) | (64'h04 << 48);
      w.kind = KIND_STATUS;
      w.last = 1'b0;
      frames_due.push_back(w);

      val = 12'(req + 1696);
      packet = {code, 4'b0000, val};
      prot = 14'(0 - (int'(packet) + int'(roll)));
      w.data = (64'(packet) << 5) | (64'(prot) << 37) | (64'(roll) << 23) | (64'd50 << 53);
      w.kind = KIND_TORQUE;
      w.last = 1'b1;
      frames_due.push_back(w);
      last_req = req;
      return 2;
   endfunction

   // Receiver: checks accepted words and stalls on a changing pattern.
   int ready_cnt = 0;
   int ready_mode = 0;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.id = rsp_ch.out_id;
         got.data = rsp_ch.out_data;
         got.kind = rsp_ch.frame_kind;
         got.last = rsp_ch.last_frame;
         frames_checked++;
         if (frames_due.size() == 0) begin
            report($sformatf("unexpected word data %h", got.data));
         end else begin
            want = frames_due.pop_front();
            if (got.id !== want.id)
               report($sformatf("out_id %h, predicted %h", got.id, want.id));
            if (got.data !== want.data)
               report($sformatf("out_data %h, predicted %h", got.data, want.data));
            if (got.kind !== want.kind)
               report($sformatf("frame_kind %b, predicted %b", got.kind, want.kind));
            if (got.last !== want.last)
               report($sformatf("last_frame %b, predicted %b", got.last, want.last));
         end
      end
      ready_cnt++;
      if (ready_cnt % 300 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= $urandom_range(0, 1);
         2: rsp_ch.ready <= (ready_cnt % 5 != 0);
         default: rsp_ch.ready <= ((ready_cnt / 16) % 2 == 0);
      endcase
   end

   // Sender: bursts of random length with random gaps in between.
   task automatic send_word(input logic [1:0] cmd, input logic [10:0] id,
                            input logic [63:0] d, input bit none_typed);
      int gap, n;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.frame_id <= id;
      req_ch.frame_data <= d;
      do @(posedge clock); while (!req_ch.ready);
      n = predict_frames(cmd, id, d);
      if (none_typed && n != 0) report("step predicted to send frames, none expected");
      if (cmd == CMD_STEP) steps_sent++;
      burst_left--;
      items_sent++;
   endtask

   // Holds the sender until every expected word has left and the block is idle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // One APB write, after which the bus returns to idle.
   task automatic csr_write(input logic [2:0] idx, input longint v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_GAIN_P: kp = sx(v, 16);
         REG_GAIN_I: ki = sx(v, 16);
         REG_GAIN_D: kd = sx(v, 16);
         REG_MIN_FRONT: gate_front = v & 'h1fff;
         REG_MIN_TORQUE: gate_torque = v & 'hfff;
         REG_SLIP_ENABLE: slip_on = sx(v, 14);
         REG_SLIP_DISABLE: slip_off = sx(v, 14);
         default: slip_set = sx(v, 14);
      endcase
   endtask

   task automatic write_all(input longint p, input longint i, input longint dg,
                            input longint mf, input longint mt, input longint en,
                            input longint dis, input longint tg);
      csr_write(REG_GAIN_P, p);
      csr_write(REG_GAIN_I, i);
      csr_write(REG_GAIN_D, dg);
      csr_write(REG_MIN_FRONT, mf);
      csr_write(REG_MIN_TORQUE, mt);
      csr_write(REG_SLIP_ENABLE, en);
      csr_write(REG_SLIP_DISABLE, dis);
      csr_write(REG_SLIP_TARGET, tg);
   endtask

   function automatic logic [63:0] wheel_data(input int f1, input int f2, input int r1,
                                              input int r2, input logic [63:0] fill);
      logic [63:0] d;
      d = moto_put(fill, 0, 12, 12'(f1));
      d = moto_put(d, 16, 12, 12'(f2));
      d = moto_put(d, 32, 12, 12'(r1));
      return moto_put(d, 48, 12, 12'(r2));
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // One pass: usually fresh frames, ticks, then control steps; else one noise word.
   task automatic run_sequence();
      int f, dlt, torque, ticks;
      logic [63:0] d;
      if ($urandom_range(0, 9) == 0) begin
         // Noise: a random command, a frame or a step, any identifier, any payload.
         case ($urandom_range(0, 2))
            0: send_word(2'($urandom_range(0, 3)), 11'($urandom), rand64(), 0);
            1: send_word(CMD_FRAME, 11'($urandom), rand64(), 0);
            default: send_word(CMD_STEP, 11'($urandom), rand64(), 0);
         endcase
         return;
      end
      if ($urandom_range(0, 5) != 0) begin
         f = $urandom_range(200, 2000);
         dlt = $signed($urandom_range(0, 1200)) - 300;
         send_word(CMD_FRAME, ID_WHEEL_SPEED,
                   wheel_data(f, f + $urandom_range(0, 60), (f + dlt / 2 < 0) ? 0 : f + dlt / 2,
                              (f + dlt / 2 < 0) ? 0 : f + dlt / 2, rand64()), 0);
      end
      if ($urandom_range(0, 5) != 0) begin
         torque = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) - 3744
                                              : $urandom_range(0, 500) - 150;
         d = moto_put(rand64(), 19, 12, 12'(torque + 1696));
         d[4] = ($urandom_range(0, 19) == 0);
         send_word(CMD_FRAME, ID_TORQUE_2, d, 0);
      end
      if ($urandom_range(0, 4) != 0) begin
         d = rand64();
         d[4] = ($urandom_range(0, 19) == 0);
         d[20] = ($urandom_range(0, 19) == 0);
         send_word(CMD_FRAME, ID_TORQUE_3, d, 0);
      end
      if ($urandom_range(0, 4) != 0) begin
         d = rand64();
         d[3:0] = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 6));
         d[4] = ($urandom_range(0, 19) == 0);
         send_word(CMD_FRAME, ID_TRANS, d, 0);
      end
      ticks = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 4);
      repeat (ticks) send_word(CMD_TICK, 11'($urandom), rand64(), 0);
      repeat ($urandom_range(1, 3)) send_word(CMD_STEP, 11'($urandom), rand64(), 0);
   endtask

   task automatic run_phase(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) run_sequence();
      drain();
   endtask

   // Directed rows: command, identifier, payload, and whether no frame is due.
   typedef struct {
      logic [1:0]  cmd;
      logic [10:0] id;
      logic [63:0] data;
      bit          none_typed;
   } row_type;
   row_type rows[$];

   function automatic void add_row(input logic [1:0] c, input logic [10:0] i,
                                   input logic [63:0] d, input bit n);
      row_type r;
      r.cmd = c;
      r.id = i;
      r.data = d;
      r.none_typed = n;
      rows.push_back(r);
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_TICK;
      req_ch.frame_id = '0;
      req_ch.frame_data = '0;
      rsp_ch.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;

      kp = 0; ki = 0; kd = 0;
      gate_front = 1280; gate_torque = 100;
      slip_on = 448; slip_off = 192; slip_set = 384;
      front_sum = 0; rear_sum = 0; drv_torque = 0;
      valid_bits = '0; gear = '0;
      for (int i = 0; i < 4; i++) age_ms[i] = 8'hff;
      latched = 0; regulating = 0;
      integ = 0; last_err = 0; last_req = 0; roll = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset state, ignored words, payload extremes, flags, gears.
      add_row(CMD_STEP, '0, '0, 1);
      add_row(2'd3, ID_TORQUE_2, '1, 1);
      add_row(CMD_FRAME, 11'h7ff, '1, 1);
      add_row(CMD_FRAME, ID_WHEEL_SPEED, '1, 1);
      add_row(CMD_FRAME, ID_WHEEL_SPEED, '0, 1);
      add_row(CMD_FRAME, ID_TORQUE_2, '0, 1);
      add_row(CMD_FRAME, ID_TORQUE_3, '0, 1);
      add_row(CMD_FRAME, ID_TRANS, '0, 1);
      add_row(CMD_STEP, '0, '0, 0);
      add_row(CMD_TICK, '1, '1, 1);
      add_row(CMD_FRAME, ID_TORQUE_2, 64'h10, 1);
      add_row(CMD_STEP, '0, '0, 1);
      add_row(CMD_FRAME, ID_TORQUE_2, moto_put('0, 19, 12, 12'h7ff), 1);
      add_row(CMD_FRAME, ID_WHEEL_SPEED, wheel_data(1000, 1000, 1400, 1400, '0), 1);
      add_row(CMD_FRAME, ID_TRANS, 64'h1, 1);
      add_row(CMD_STEP, '0, '0, 0);
      add_row(CMD_STEP, '0, '0, 0);
      add_row(CMD_FRAME, ID_TRANS, 64'h7, 1);
      add_row(CMD_STEP, '0, '0, 0);
      add_row(CMD_FRAME, ID_TRANS, 64'hf, 1);
      add_row(CMD_STEP, '0, '0, 0);
      add_row(CMD_FRAME, ID_TORQUE_3, 64'h10_0000, 1);
      add_row(CMD_STEP, '0, '0, 1);
      add_row(CMD_FRAME, ID_TORQUE_3, '1, 1);
      add_row(CMD_STEP, '1, '1, 1);
      foreach (rows[i]) send_word(rows[i].cmd, rows[i].id, rows[i].data, rows[i].none_typed);
      drain();

      // Reset settings, then long tick run so the age counters saturate.
      repeat (300) send_word(CMD_TICK, '0, '0, 0);
      run_phase(ITEMS_PER_PHASE);

      write_all(256, 128, 64, 1280, 100, 448, 192, 384);
      run_phase(ITEMS_PER_PHASE / 2);
      // Sender holds until all frames are out, then resumes.
      drain();
      run_phase(ITEMS_PER_PHASE / 2);

      write_all(32767, 32767, 32767, 0, 0, -8192, -8192, 8191);
      run_phase(ITEMS_PER_PHASE);

      write_all(-32768, -32768, -32768, 8191, 4095, 8191, 8191, -8192);
      run_phase(ITEMS_PER_PHASE / 2);

      write_all($urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                $urandom_range(0, 2048) - 1024, $urandom_range(500, 2500),
                $urandom_range(0, 200), $urandom_range(200, 800), $urandom_range(0, 400),
                $urandom_range(0, 800) - 200);
      run_phase(ITEMS_PER_PHASE);

      write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 3000),
                $urandom_range(0, 300), $urandom_range(0, 16383),
                $urandom_range(0, 16383), $urandom_range(0, 16383));
      run_phase(ITEMS_PER_PHASE);

      if (frames_due.size() != 0)
         report($sformatf("%0d predicted words never arrived", frames_due.size()));
      $display("Run covered %0d command words, %0d control steps, %0d frame words checked",
               items_sent, steps_sent, frames_checked);
      $display("Six register settings including both extremes were applied");
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #30ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tcc_pkg.sv
src/tcc_if.sv
src/tcc_div.sv
src/tcc_ctrl.sv
src/tcc_dp.sv
src/traction_control_can_node.sv
bench/tb.sv
